@@ sv/isps_pkg.sv @@
// Shared types and constants for the IMU SPI poll sequencer.
package isps_pkg;

  localparam logic [7:0] READ_BIT      = 8'h80;
  localparam logic [7:0] GYRO_CFG_REG  = 8'h1B;
  localparam logic [7:0] ACCEL_CFG_REG = 8'h1C;
  localparam logic [7:0] ACCEL_OUT_REG = 8'h3B;
  localparam logic [7:0] GYRO_OUT_REG  = 8'h43;

  localparam logic [2:0] WRITE_LEN  = 3'd2;
  localparam logic [2:0] READ_LEN   = 3'd7;
  localparam logic [2:0] RX_SAT     = 3'd7;
  localparam int         STORE_DEPTH = 6;
  localparam int         AXES        = 3;

  // Configuration register indexes.
  localparam logic CFG_ACCEL_RANGE = 1'b0;
  localparam logic CFG_GYRO_RANGE  = 1'b1;

  typedef enum logic [4:0] {
    PH_INIT_ACC  = 5'b00001,
    PH_INIT_GYRO = 5'b00010,
    PH_POLL_ACC  = 5'b00100,
    PH_READ_ACC  = 5'b01000,
    PH_READ_GYRO = 5'b10000
  } phase_t;

  // One queued command burst with the axis values that travel with it.
  typedef struct packed {
    logic [7:0]            first_byte;
    logic [7:0]            second_byte;
    logic                  is_read;
    logic [AXES-1:0][15:0] accel;
    logic [AXES-1:0][15:0] gyro;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ sv/imu_spi_poll_sequencer.sv @@
// Top level of the IMU SPI poll sequencer: front end, command queue, back end.
// Each input beat (a kick or one received SPI byte) is taken while the
// two-entry command queue has room, so beats may arrive back to back.
// A beat that triggers a command queues one burst: a two-byte range write or a
// seven-byte burst read. The back end sends one command byte per cycle while
// the sink is ready; input stalls only while two bursts are waiting in the
// queue. Every output beat carries the axis values as they stood after the
// input beat that caused it.
module imu_spi_poll_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_tx_byte,
  output logic               out_tx_last,
  output logic signed [15:0] out_accel_x,
  output logic signed [15:0] out_accel_y,
  output logic signed [15:0] out_accel_z,
  output logic signed [15:0] out_gyro_x,
  output logic signed [15:0] out_gyro_y,
  output logic signed [15:0] out_gyro_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_data
);

  logic                in_accept;
  logic                push, pop;
  isps_pkg::cmd_t      push_cmd, head;
  isps_pkg::q_status_t q_status;

  assign in_ready  = !q_status.full;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  isps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_func    (in_func),
    .in_rx_byte (in_rx_byte),
    .cfg_accept (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  isps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  isps_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .head_valid  (!q_status.empty),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .pop         (pop),
    .out_tx_byte (out_tx_byte),
    .out_tx_last (out_tx_last)
  );

  assign out_accel_x = $signed(head.accel[0]);
  assign out_accel_y = $signed(head.accel[1]);
  assign out_accel_z = $signed(head.accel[2]);
  assign out_gyro_x  = $signed(head.gyro[0]);
  assign out_gyro_y  = $signed(head.gyro[1]);
  assign out_gyro_z  = $signed(head.gyro[2]);

  // A burst never breaks off: after a beat that is not the last, the next is ready.
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_tx_last |=> out_valid)
    else $error("command burst broke off before its last beat");

  // Beats after the first are zeros or a range code, which has its low three bits clear.
  a_tail_byte_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_tx_last |=> out_tx_byte[2:0] == 3'b000)
    else $error("tail beat of a command burst has a malformed byte");

  // The queue cannot be full and empty together, and a full queue blocks input.
  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> !q_status.empty && !in_ready)
    else $error("command queue status is inconsistent");

  // Pushing into a full queue would lose a burst.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> !push)
    else $error("command pushed into a full queue");

endmodule

@@ sv/isps_front.sv @@
// Front end: takes received bytes and kicks, steps the phase, latches axis data.
module isps_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_accept,
  input  logic                 in_func,
  input  logic [7:0]           in_rx_byte,
  input  logic                 cfg_accept,
  input  logic                 cfg_index,
  input  logic [1:0]           cfg_data,
  output logic                 push,
  output isps_pkg::cmd_t       push_cmd
);

  isps_pkg::phase_t phase_r, phase_nxt;
  logic [2:0] rx_count_r, rx_count_nxt;
  logic [1:0] accel_code_r, gyro_code_r;
  logic [isps_pkg::STORE_DEPTH-1:0][7:0] store_r, store_nxt;
  logic [isps_pkg::AXES-1:0][15:0] accel_r, accel_nxt, gyro_r, gyro_nxt;
  logic [2:0] cnt;
  logic [2:0] store_idx;
  logic       emit;
  logic [7:0] first_byte, second_byte;
  logic       is_read;

  assign store_idx = rx_count_r - 3'd1;

  always_comb begin
    store_nxt = store_r;
    cnt       = rx_count_r;
    if (in_func && rx_count_r < isps_pkg::RX_SAT) begin
      if (rx_count_r != 3'd0) begin
        store_nxt[store_idx] = in_rx_byte;
      end
      cnt = rx_count_r + 3'd1;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    rx_count_nxt = cnt;
    accel_nxt    = accel_r;
    gyro_nxt     = gyro_r;
    emit         = 1'b0;
    is_read      = 1'b0;
    first_byte   = isps_pkg::ACCEL_CFG_REG;
    second_byte  = '0;
    unique case (phase_r)
      isps_pkg::PH_INIT_ACC: begin
        emit         = 1'b1;
        first_byte   = isps_pkg::ACCEL_CFG_REG;
        second_byte  = {3'b000, accel_code_r, 3'b000};
        rx_count_nxt = '0;
        phase_nxt    = isps_pkg::PH_INIT_GYRO;
      end
      isps_pkg::PH_INIT_GYRO: begin
        if (cnt == isps_pkg::WRITE_LEN) begin
          emit         = 1'b1;
          first_byte   = isps_pkg::GYRO_CFG_REG;
          second_byte  = {3'b000, gyro_code_r, 3'b000};
          rx_count_nxt = '0;
          phase_nxt    = isps_pkg::PH_POLL_ACC;
        end
      end
      isps_pkg::PH_POLL_ACC: begin
        if (cnt == isps_pkg::WRITE_LEN) begin
          emit         = 1'b1;
          is_read      = 1'b1;
          first_byte   = isps_pkg::READ_BIT | isps_pkg::ACCEL_OUT_REG;
          rx_count_nxt = '0;
          phase_nxt    = isps_pkg::PH_READ_ACC;
        end
      end
      isps_pkg::PH_READ_ACC: begin
        if (cnt == isps_pkg::READ_LEN) begin
          for (int i = 0; i < isps_pkg::AXES; i++) begin
            accel_nxt[i] = {store_nxt[2*i], store_nxt[2*i+1]};
          end
          emit         = 1'b1;
          is_read      = 1'b1;
          first_byte   = isps_pkg::READ_BIT | isps_pkg::GYRO_OUT_REG;
          rx_count_nxt = '0;
          phase_nxt    = isps_pkg::PH_READ_GYRO;
        end
      end
      isps_pkg::PH_READ_GYRO: begin
        if (cnt == isps_pkg::READ_LEN) begin
          for (int i = 0; i < isps_pkg::AXES; i++) begin
            gyro_nxt[i] = {store_nxt[2*i], store_nxt[2*i+1]};
          end
          emit         = 1'b1;
          is_read      = 1'b1;
          first_byte   = isps_pkg::READ_BIT | isps_pkg::ACCEL_OUT_REG;
          rx_count_nxt = '0;
          phase_nxt    = isps_pkg::PH_READ_ACC;
        end
      end
      default: begin
      end
    endcase
  end

  // A kick outside the start phase changes nothing, which falls out of the logic above.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= isps_pkg::PH_INIT_ACC;
      rx_count_r   <= '0;
      accel_r      <= '0;
      gyro_r       <= '0;
      accel_code_r <= 2'd0;
      gyro_code_r  <= 2'd1;
    end else begin
      if (in_accept) begin
        phase_r    <= phase_nxt;
        rx_count_r <= rx_count_nxt;
        accel_r    <= accel_nxt;
        gyro_r     <= gyro_nxt;
      end
      if (cfg_accept) begin
        unique case (cfg_index)
          isps_pkg::CFG_ACCEL_RANGE: accel_code_r <= cfg_data;
          isps_pkg::CFG_GYRO_RANGE:  gyro_code_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      store_r <= store_nxt;
    end
  end

  assign push                 = in_accept && emit;
  assign push_cmd.first_byte  = first_byte;
  assign push_cmd.second_byte = second_byte;
  assign push_cmd.is_read     = is_read;
  assign push_cmd.accel       = accel_nxt;
  assign push_cmd.gyro        = gyro_nxt;

endmodule

@@ sv/isps_queue.sv @@
// Two-entry command queue between the front and back ends.
module isps_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  isps_pkg::cmd_t       push_cmd,
  input  logic                 pop,
  output isps_pkg::cmd_t       head,
  output isps_pkg::q_status_t  status
);

  isps_pkg::cmd_t entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head         = entry_r[rd_ptr_r];
  assign status.full  = count_r == 2'd2;
  assign status.empty = count_r == 2'd0;

endmodule

@@ sv/isps_back.sv @@
// Back end: expands the queued command at the head into its byte beats.
module isps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  isps_pkg::cmd_t       head,
  input  logic                 head_valid,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 pop,
  output logic [7:0]           out_tx_byte,
  output logic                 out_tx_last
);

  logic [2:0] beat_r, beat_nxt;
  logic [2:0] last_beat;
  logic       out_accept;

  assign last_beat  = head.is_read ? (isps_pkg::READ_LEN - 3'd1) : (isps_pkg::WRITE_LEN - 3'd1);
  assign out_valid  = head_valid;
  assign out_accept = out_valid && out_ready;
  assign out_tx_last = beat_r == last_beat;
  assign pop        = out_accept && out_tx_last;

  always_comb begin
    if (beat_r == 3'd0) begin
      out_tx_byte = head.first_byte;
    end else if (head.is_read) begin
      out_tx_byte = '0;
    end else begin
      out_tx_byte = head.second_byte;
    end
  end

  always_comb begin
    beat_nxt = beat_r;
    if (pop) begin
      beat_nxt = '0;
    end else if (out_accept) begin
      beat_nxt = beat_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

endmodule
